>>> hdl/lsd_pkg.sv
package lsd_pkg;

    // Pixel store size and the widths that follow from it.
    localparam int MAX_LEDS = 256;
    localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int PTR_W = $clog2(MAX_LEDS + 1);

    // Pixel word layout and bit counter.
    localparam int WORD_W = 24;
    localparam int BIT_PTR_W = 5;
    localparam logic [BIT_PTR_W-1:0] LAST_BIT = BIT_PTR_W'(WORD_W - 1);

    // Field and register widths.
    localparam int REQ_W = 3;
    localparam int INDEX_W = 16;
    localparam int LEVEL_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 9;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TICK      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_COLOR = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_SHOW  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SHOW      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd4;

    // Configuration reset values.
    localparam logic [COUNT_W-1:0] LED_COUNT_RST  = 9'd0;
    localparam logic [7:0]         ONE_HIGH_RST   = 8'd13;
    localparam logic [7:0]         ZERO_HIGH_RST  = 8'd6;
    localparam logic [7:0]         BIT_PERIOD_RST = 8'd20;
    localparam logic [TICK_W-1:0]  RESET_LOW_RST  = 16'd800;

    // Commands from the frame controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              shift;
        logic              clear;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } dp_cmd_t;

    // Status from the datapath to the frame controller.
    typedef struct packed {
        logic [7:0]        high_ticks;
        logic [7:0]        period;
        logic [TICK_W-1:0] reset_need;
        logic [PTR_W-1:0]  pixels_in_use;
    } dp_stat_t;

endpackage

>>> hdl/rgb_led_strip_serial_driver.sv
// One-wire LED strip driver with a 256-pixel green-red-blue store. Every accepted
// request, a tick or a command, gives exactly one result in the next cycle, and a new
// request is accepted every cycle while the result slot is free or being taken, so
// the sustained rate is one request per clock. A tick advances the line waveform by
// one step; the frame controller works through the reset-low phase, then 24 bits per
// pixel. The pixel memory has a registered read port, so the next pixel is fetched
// ahead while the current one is on the line. Commands during a frame are refused.
// Configuration may be written only while no frame is running.
module rgb_led_strip_serial_driver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lsd_pkg::REQ_W-1:0]         req_type,
    input  logic [lsd_pkg::INDEX_W-1:0]       pixel_index,
    input  logic [lsd_pkg::LEVEL_W-1:0]       red_level,
    input  logic [lsd_pkg::LEVEL_W-1:0]       green_level,
    input  logic [lsd_pkg::LEVEL_W-1:0]       blue_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              line_level,
    output logic                              frame_busy,
    output logic [lsd_pkg::STATUS_W-1:0]      status
);
    import lsd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Frame sequencer and request handling.
    lsd_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pixel_index (pixel_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_level  (line_level),
        .frame_busy  (frame_busy),
        .status      (status),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Pixel store, shift register and configuration.
    lsd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> hdl/lsd_datapath.sv
module lsd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  lsd_pkg::dp_cmd_t                    cmd,
    output lsd_pkg::dp_stat_t                   stat
);
    import lsd_pkg::*;

    logic [COUNT_W-1:0] led_count_reg;
    logic [7:0]         one_high_reg;
    logic [7:0]         zero_high_reg;
    logic [7:0]         bit_period_reg;
    logic [TICK_W-1:0]  reset_low_reg;

    logic [WORD_W-1:0]  mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] valid_reg;
    logic [WORD_W-1:0]  mem_q_reg;
    logic               valid_q_reg;
    logic               fwd_hit_reg;
    logic [WORD_W-1:0]  fwd_data_reg;
    logic [WORD_W-1:0]  pixel_word;
    logic [WORD_W-1:0]  shift_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg  <= LED_COUNT_RST;
            one_high_reg   <= ONE_HIGH_RST;
            zero_high_reg  <= ZERO_HIGH_RST;
            bit_period_reg <= BIT_PERIOD_RST;
            reset_low_reg  <= RESET_LOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LED_COUNT:  led_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_ONE_HIGH:   one_high_reg   <= cfg_data[7:0];
                CFG_ZERO_HIGH:  zero_high_reg  <= cfg_data[7:0];
                CFG_BIT_PERIOD: bit_period_reg <= cfg_data[7:0];
                CFG_RESET_LOW:  reset_low_reg  <= cfg_data[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pixel memory write port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    // Pixel memory registered read port.
    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[cmd.rd_addr];
        fwd_data_reg <= cmd.wr_data;
    end

    // Written flags: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[cmd.wr_addr] <= 1'b1;
            end
            valid_q_reg <= valid_reg[cmd.rd_addr];
            fwd_hit_reg <= cmd.wr_en && (cmd.wr_addr == cmd.rd_addr);
        end
    end

    // A write to the address being read in the same cycle is forwarded.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            pixel_word = fwd_data_reg;
        end
        else if (valid_q_reg)
        begin
            pixel_word = mem_q_reg;
        end
        else
        begin
            pixel_word = '0;
        end
    end

    // Output shift register, most significant bit on the line first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
        end
        else if (cmd.load)
        begin
            shift_reg <= pixel_word;
        end
        else if (cmd.clear)
        begin
            shift_reg <= '0;
        end
        else if (cmd.shift)
        begin
            shift_reg <= {shift_reg[WORD_W-2:0], 1'b0};
        end
    end

    // Derived timing values for the controller.
    always_comb
    begin
        stat.high_ticks = shift_reg[WORD_W-1] ? one_high_reg : zero_high_reg;
        stat.period = (bit_period_reg == 8'd0) ? 8'd1 : bit_period_reg;
        stat.reset_need = (reset_low_reg == '0) ? TICK_W'(1) : reset_low_reg;
        if (32'(led_count_reg) > MAX_LEDS)
        begin
            stat.pixels_in_use = PTR_W'(MAX_LEDS);
        end
        else
        begin
            stat.pixels_in_use = PTR_W'(led_count_reg);
        end
    end

endmodule

>>> hdl/lsd_controller.sv
module lsd_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lsd_pkg::REQ_W-1:0]         req_type,
    input  logic [lsd_pkg::INDEX_W-1:0]       pixel_index,
    input  logic [lsd_pkg::LEVEL_W-1:0]       red_level,
    input  logic [lsd_pkg::LEVEL_W-1:0]       green_level,
    input  logic [lsd_pkg::LEVEL_W-1:0]       blue_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              line_level,
    output logic                              frame_busy,
    output logic [lsd_pkg::STATUS_W-1:0]      status,
    output lsd_pkg::dp_cmd_t                  cmd,
    input  lsd_pkg::dp_stat_t                 stat
);
    import lsd_pkg::*;

    // Frame states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RESET = 2'd1;
    localparam logic [1:0] ST_BITS  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic                 clearing_reg, clearing_next;
    logic [PTR_W-1:0]     pixel_ptr_reg, pixel_ptr_next;
    logic [BIT_PTR_W-1:0] bit_ptr_reg, bit_ptr_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 level_reg, level_next;
    logic                 busy_reg, busy_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 accept;
    logic                 sending;
    logic                 cur_level;
    logic [TICK_W-1:0]    tick_inc;
    logic                 do_load;
    logic [PTR_W-1:0]     load_ptr;
    logic                 in_range;

    // Handshake: a new request is taken whenever the result slot frees up.
    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;
    assign sending = (state_reg != ST_IDLE);
    assign cur_level = (state_reg == ST_BITS) && (tick_reg < TICK_W'(stat.high_ticks));
    assign tick_inc = tick_reg + TICK_W'(1);
    assign in_range = (32'(pixel_index) < 32'(stat.pixels_in_use));

    // Request decode and frame sequencing.
    always_comb
    begin
        state_next = state_reg;
        clearing_next = clearing_reg;
        pixel_ptr_next = pixel_ptr_reg;
        bit_ptr_next = bit_ptr_reg;
        tick_next = tick_reg;
        out_valid_next = out_valid_reg;
        level_next = level_reg;
        busy_next = busy_reg;
        status_next = status_reg;
        do_load = 1'b0;
        load_ptr = '0;
        cmd = '0;
        cmd.wr_data = {green_level, red_level, blue_level};
        cmd.wr_addr = pixel_index[ADDR_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            level_next = cur_level;
            busy_next = sending;
            status_next = STATUS_OK;
            unique case (req_type)
                REQ_TICK:
                begin
                    unique case (state_reg)
                        ST_RESET:
                        begin
                            if (tick_inc >= stat.reset_need)
                            begin
                                do_load = 1'b1;
                                load_ptr = '0;
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        ST_BITS:
                        begin
                            if (tick_inc >= TICK_W'(stat.period))
                            begin
                                tick_next = '0;
                                cmd.shift = 1'b1;
                                bit_ptr_next = bit_ptr_reg + BIT_PTR_W'(1);
                                if (bit_ptr_reg == LAST_BIT)
                                begin
                                    do_load = 1'b1;
                                    load_ptr = pixel_ptr_reg + PTR_W'(1);
                                end
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                REQ_SET_COLOR, REQ_SET_SHOW, REQ_SHOW, REQ_CLEAR:
                begin
                    if (sending)
                    begin
                        status_next = STATUS_REFUSED;
                    end
                    else
                    begin
                        if ((req_type == REQ_SET_COLOR || req_type == REQ_SET_SHOW) &&
                            !in_range)
                        begin
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            if (req_type == REQ_SET_COLOR || req_type == REQ_SET_SHOW)
                            begin
                                cmd.wr_en = 1'b1;
                            end
                            if (req_type != REQ_SET_COLOR)
                            begin
                                state_next = ST_RESET;
                                clearing_next = (req_type == REQ_CLEAR);
                                pixel_ptr_next = '0;
                                bit_ptr_next = '0;
                                tick_next = '0;
                                cmd.clear = 1'b1;
                                busy_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Move to the next pixel or finish the frame.
        if (do_load)
        begin
            bit_ptr_next = '0;
            tick_next = '0;
            if (load_ptr >= stat.pixels_in_use)
            begin
                state_next = ST_IDLE;
                clearing_next = 1'b0;
                pixel_ptr_next = '0;
                cmd.clear = 1'b1;
            end
            else
            begin
                state_next = ST_BITS;
                pixel_ptr_next = load_ptr;
                cmd.load = 1'b1;
                if (clearing_reg)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = load_ptr[ADDR_W-1:0];
                    cmd.wr_data = '0;
                end
            end
        end

        // Prefetch the pixel that the next load will need.
        if (state_next == ST_BITS)
        begin
            cmd.rd_addr = ADDR_W'(pixel_ptr_next + PTR_W'(1));
        end
        else
        begin
            cmd.rd_addr = '0;
        end
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clearing_reg <= 1'b0;
            pixel_ptr_reg <= '0;
            bit_ptr_reg <= '0;
            tick_reg <= '0;
            out_valid_reg <= 1'b0;
            level_reg <= 1'b0;
            busy_reg <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            clearing_reg <= clearing_next;
            pixel_ptr_reg <= pixel_ptr_next;
            bit_ptr_reg <= bit_ptr_next;
            tick_reg <= tick_next;
            out_valid_reg <= out_valid_next;
            level_reg <= level_next;
            busy_reg <= busy_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_level = level_reg;
    assign frame_busy = busy_reg;
    assign status = status_reg;

    // An idle controller keeps its counters cleared.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pixel_ptr_reg == '0 && tick_reg == '0 &&
                                    bit_ptr_reg == '0 && !clearing_reg))
        else $error("idle controller holds stale frame counters");

    // The bit counter never passes the last bit of a pixel.
    a_bit_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_ptr_reg <= LAST_BIT)
        else $error("bit pointer out of range");

    // A refused command is always reported as busy.
    a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_REFUSED) |-> busy_reg)
        else $error("refused command reported while not busy");

    // The line is only driven high while data bits are being sent.
    a_level_in_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cur_level) |-> (state_reg == ST_BITS))
        else $error("line high outside the data phase");

    // The pixel pointer stays within the store during the data phase.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BITS) |-> (32'(pixel_ptr_reg) < MAX_LEDS))
        else $error("pixel pointer beyond the store");

endmodule
